FILE: design/dpss_pkg.sv
// dpss_pkg: shared types, codes and constants for the drive power state sequencer.
// No dependencies; used by the channel interfaces and the top level.

package dpss_pkg;

    localparam int STATUS_W  = 16;
    localparam int TIME_W    = 32;
    localparam int CMD_W     = 2;
    localparam int STATE_W   = 3;
    localparam int CTRL_W    = 16;
    localparam int MASK_W    = 16;
    localparam int DELAY_W   = 16;
    localparam int TIMEOUT_W = 20;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 20;

    // command codes
    localparam logic [CMD_W-1:0] CMD_NONE    = 2'd0;
    localparam logic [CMD_W-1:0] CMD_ENABLE  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_DISABLE = 2'd2;

    // phase codes
    localparam logic [STATE_W-1:0] PH_OFF        = 3'd0;
    localparam logic [STATE_W-1:0] PH_RESET_WAIT = 3'd1;
    localparam logic [STATE_W-1:0] PH_PREPARE    = 3'd2;
    localparam logic [STATE_W-1:0] PH_SWITCH_ON  = 3'd3;
    localparam logic [STATE_W-1:0] PH_ON         = 3'd4;
    localparam logic [STATE_W-1:0] PH_FAULT      = 3'd5;

    // control words
    localparam logic [CTRL_W-1:0] CW_FAULT_RESET  = 16'h0080;
    localparam logic [CTRL_W-1:0] CW_SHUTDOWN     = 16'h0006;
    localparam logic [CTRL_W-1:0] CW_ENABLE_OP    = 16'h000F;
    localparam logic [CTRL_W-1:0] CW_DISABLE_VOLT = 16'h0000;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_FAULT_MASK      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_READY_MASK      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ENABLED_MASK    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DISABLED_MASK   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_FAULT_SETTLE_MS = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_RESET_DELAY_MS  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_INIT_TIMEOUT_MS = 3'd6;

    // register reset values
    localparam logic [MASK_W-1:0]    RST_FAULT_MASK      = 16'd8;
    localparam logic [MASK_W-1:0]    RST_READY_MASK      = 16'd33;
    localparam logic [MASK_W-1:0]    RST_ENABLED_MASK    = 16'd39;
    localparam logic [MASK_W-1:0]    RST_DISABLED_MASK   = 16'd64;
    localparam logic [DELAY_W-1:0]   RST_FAULT_SETTLE_MS = 16'd1000;
    localparam logic [DELAY_W-1:0]   RST_RESET_DELAY_MS  = 16'd1000;
    localparam logic [TIMEOUT_W-1:0] RST_INIT_TIMEOUT_MS = 20'd10000;

    typedef struct packed {
        logic [CMD_W-1:0]    cmd;
        logic [STATUS_W-1:0] status_in;
        logic [TIME_W-1:0]   now_ms;
    } in_item_t;

    typedef struct packed {
        logic [CTRL_W-1:0]  control_out;
        logic [STATE_W-1:0] drive_state;
        logic [CMD_W-1:0]   pending_cmd;
        logic               timed_out;
    } out_item_t;

    function automatic logic all_set(input logic [STATUS_W-1:0] status,
                                     input logic [MASK_W-1:0] mask);
        return (status & mask) == mask;
    endfunction

endpackage

FILE: design/dpss_in_if.sv
// dpss_in_if: valid/ready channel carrying one status item.
// Depends on dpss_pkg.

interface dpss_in_if;
    logic               valid;
    logic               ready;
    dpss_pkg::in_item_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

FILE: design/dpss_out_if.sv
// dpss_out_if: valid/ready channel carrying one result item.
// Depends on dpss_pkg.

interface dpss_out_if;
    logic                valid;
    logic                ready;
    dpss_pkg::out_item_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

FILE: design/dpss_cfg_if.sv
// dpss_cfg_if: register write channel, index plus write data.
// Depends on dpss_pkg.

interface dpss_cfg_if;
    logic                               valid;
    logic                               ready;
    logic [dpss_pkg::CFG_IDX_W-1:0]     idx;
    logic [dpss_pkg::CFG_DATA_W-1:0]    wdata;

    modport source (output valid, output idx, output wdata, input ready);
    modport sink   (input valid, input idx, input wdata, output ready);
endinterface

FILE: design/drive_power_state_sequencer.sv
// drive_power_state_sequencer: CiA 402 style power sequencing for a servo drive.
// Depends on dpss_pkg, dpss_in_if, dpss_out_if, dpss_cfg_if.
//
//   Channel   Dir   Payload                                  Transfer when
//   items     in    cmd, status_in, now_ms                   valid && ready
//   results   out   control_out, drive_state, pending_cmd,   valid && ready
//                   timed_out
//   cfg       in    idx (register index), wdata              valid && ready
//
// One item per clock while results are taken; items pass the input register,
// then the step logic into the result register. The step path is one 32-bit
// subtract and compare. Reset clears the phase, pending command and stamp
// and loads register defaults; no clearing pass. A stalled result holds the
// input stage, which still takes one item and then deasserts ready.

module drive_power_state_sequencer (
    input  logic              clk,
    input  logic              rst_n,
    dpss_in_if.sink           items,
    dpss_out_if.source        results,
    dpss_cfg_if.sink          cfg
);

    // configuration registers
    logic [dpss_pkg::MASK_W-1:0]    fault_mask_reg;
    logic [dpss_pkg::MASK_W-1:0]    ready_mask_reg;
    logic [dpss_pkg::MASK_W-1:0]    enabled_mask_reg;
    logic [dpss_pkg::MASK_W-1:0]    disabled_mask_reg;
    logic [dpss_pkg::DELAY_W-1:0]   fault_settle_ms_reg;
    logic [dpss_pkg::DELAY_W-1:0]   reset_delay_ms_reg;
    logic [dpss_pkg::TIMEOUT_W-1:0] init_timeout_ms_reg;

    // sequencer state
    logic [dpss_pkg::STATE_W-1:0] phase_reg, phase_next;
    logic [dpss_pkg::CMD_W-1:0]   command_held_reg, command_held_next;
    logic [dpss_pkg::TIME_W-1:0]  start_stamp_reg, start_stamp_next;
    logic                         stamp_taken_reg, stamp_taken_next;
    logic [dpss_pkg::CTRL_W-1:0]  control_held_reg, control_held_next;

    // pipeline
    logic                  in_valid_reg;
    dpss_pkg::in_item_t    in_data_reg;
    logic                  out_valid_reg;
    dpss_pkg::out_item_t   out_data_reg, out_data_next;
    logic                  advance;
    logic                  timed_out_next;
    logic [dpss_pkg::TIME_W-1:0] elapsed;
    logic [dpss_pkg::DELAY_W:0]  wait_limit;

    assign advance       = in_valid_reg && (!out_valid_reg || results.ready);
    assign items.ready   = !in_valid_reg || advance;
    assign cfg.ready     = 1'b1;
    assign results.valid = out_valid_reg;
    assign results.data  = out_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fault_mask_reg      <= dpss_pkg::RST_FAULT_MASK;
            ready_mask_reg      <= dpss_pkg::RST_READY_MASK;
            enabled_mask_reg    <= dpss_pkg::RST_ENABLED_MASK;
            disabled_mask_reg   <= dpss_pkg::RST_DISABLED_MASK;
            fault_settle_ms_reg <= dpss_pkg::RST_FAULT_SETTLE_MS;
            reset_delay_ms_reg  <= dpss_pkg::RST_RESET_DELAY_MS;
            init_timeout_ms_reg <= dpss_pkg::RST_INIT_TIMEOUT_MS;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.idx)
                dpss_pkg::REG_FAULT_MASK:
                    fault_mask_reg <= cfg.wdata[dpss_pkg::MASK_W-1:0];
                dpss_pkg::REG_READY_MASK:
                    ready_mask_reg <= cfg.wdata[dpss_pkg::MASK_W-1:0];
                dpss_pkg::REG_ENABLED_MASK:
                    enabled_mask_reg <= cfg.wdata[dpss_pkg::MASK_W-1:0];
                dpss_pkg::REG_DISABLED_MASK:
                    disabled_mask_reg <= cfg.wdata[dpss_pkg::MASK_W-1:0];
                dpss_pkg::REG_FAULT_SETTLE_MS:
                    fault_settle_ms_reg <= cfg.wdata[dpss_pkg::DELAY_W-1:0];
                dpss_pkg::REG_RESET_DELAY_MS:
                    reset_delay_ms_reg <= cfg.wdata[dpss_pkg::DELAY_W-1:0];
                dpss_pkg::REG_INIT_TIMEOUT_MS:
                    init_timeout_ms_reg <= cfg.wdata[dpss_pkg::TIMEOUT_W-1:0];
                default:
                    ;
            endcase
        end
    end

    // step logic
    always_comb
    begin
        phase_next        = phase_reg;
        command_held_next = command_held_reg;
        start_stamp_next  = start_stamp_reg;
        stamp_taken_next  = stamp_taken_reg;
        control_held_next = control_held_reg;
        timed_out_next    = 1'b0;

        if (in_data_reg.cmd == dpss_pkg::CMD_ENABLE ||
            in_data_reg.cmd == dpss_pkg::CMD_DISABLE)
            command_held_next = in_data_reg.cmd;

        if (phase_reg == dpss_pkg::PH_OFF && !stamp_taken_reg)
            start_stamp_next = in_data_reg.now_ms;
        elapsed    = in_data_reg.now_ms - start_stamp_next;
        wait_limit = {1'b0, fault_settle_ms_reg} + {1'b0, reset_delay_ms_reg};

        if (command_held_next == dpss_pkg::CMD_ENABLE)
        begin
            stamp_taken_next = stamp_taken_reg || (phase_reg == dpss_pkg::PH_OFF);
            unique case (phase_reg)
                dpss_pkg::PH_OFF:
                begin
                    control_held_next = dpss_pkg::CW_FAULT_RESET;
                    if (!dpss_pkg::all_set(in_data_reg.status_in, fault_mask_reg) &&
                        elapsed > {16'd0, fault_settle_ms_reg})
                        phase_next = dpss_pkg::PH_RESET_WAIT;
                end
                dpss_pkg::PH_RESET_WAIT:
                begin
                    control_held_next = dpss_pkg::CW_SHUTDOWN;
                    if (elapsed > {15'd0, wait_limit})
                        phase_next = dpss_pkg::PH_PREPARE;
                end
                dpss_pkg::PH_PREPARE:
                begin
                    control_held_next = dpss_pkg::CW_SHUTDOWN;
                    if (dpss_pkg::all_set(in_data_reg.status_in, ready_mask_reg))
                        phase_next = dpss_pkg::PH_SWITCH_ON;
                end
                dpss_pkg::PH_SWITCH_ON:
                begin
                    control_held_next = dpss_pkg::CW_ENABLE_OP;
                    if (dpss_pkg::all_set(in_data_reg.status_in, enabled_mask_reg))
                    begin
                        phase_next        = dpss_pkg::PH_ON;
                        command_held_next = dpss_pkg::CMD_NONE;
                    end
                end
                default:
                    ;
            endcase
            if (phase_next != dpss_pkg::PH_ON && phase_next != dpss_pkg::PH_FAULT &&
                phase_next != dpss_pkg::PH_OFF &&
                elapsed > {12'd0, init_timeout_ms_reg})
            begin
                phase_next       = dpss_pkg::PH_OFF;
                stamp_taken_next = 1'b0;
                timed_out_next   = 1'b1;
            end
        end
        else if (command_held_next == dpss_pkg::CMD_DISABLE)
        begin
            start_stamp_next  = start_stamp_reg;
            control_held_next = dpss_pkg::CW_DISABLE_VOLT;
            if (dpss_pkg::all_set(in_data_reg.status_in, disabled_mask_reg))
            begin
                phase_next        = dpss_pkg::PH_OFF;
                stamp_taken_next  = 1'b0;
                command_held_next = dpss_pkg::CMD_NONE;
            end
        end
        else
        begin
            start_stamp_next = start_stamp_reg;
        end

        out_data_next.control_out = control_held_next;
        out_data_next.drive_state = phase_next;
        out_data_next.pending_cmd = command_held_next;
        out_data_next.timed_out   = timed_out_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg     <= 1'b0;
            out_valid_reg    <= 1'b0;
            phase_reg        <= dpss_pkg::PH_OFF;
            command_held_reg <= dpss_pkg::CMD_NONE;
            start_stamp_reg  <= '0;
            stamp_taken_reg  <= 1'b0;
            control_held_reg <= '0;
        end
        else
        begin
            if (items.ready)
                in_valid_reg <= items.valid;
            if (advance)
            begin
                out_valid_reg    <= 1'b1;
                phase_reg        <= phase_next;
                command_held_reg <= command_held_next;
                start_stamp_reg  <= start_stamp_next;
                stamp_taken_reg  <= stamp_taken_next;
                control_held_reg <= control_held_next;
            end
            else if (results.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (items.valid && items.ready)
            in_data_reg <= items.data;
        if (advance)
            out_data_reg <= out_data_next;
    end

    // a timeout always lands in off with enable still pending
    a_timeout_off: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_data_reg.timed_out |->
            out_data_reg.drive_state == dpss_pkg::PH_OFF &&
            out_data_reg.pending_cmd == dpss_pkg::CMD_ENABLE)
        else $error("timeout result not in off with enable pending");

    // any phase past off was reached through a taken start stamp
    a_stamp_taken: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg != dpss_pkg::PH_OFF |-> stamp_taken_reg)
        else $error("phase left off without a start stamp");

    // state only moves when an item is stepped into the result register
    a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !advance |=> $stable(phase_reg) && $stable(command_held_reg) &&
            $stable(control_held_reg))
        else $error("sequencer state changed without a step");

endmodule
